>>> rtl/ghe_pkg.sv
package ghe_pkg;

   typedef logic [7:0][63:0] sbox_type;

   typedef struct packed {
      logic         finish;
      logic         has_block;
      logic [255:0] block;
      logic [4:0]   nbytes;
   } qent_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cmp_stat_type;

   localparam logic [255:0] C3_CONST = {64'hff00ffff000000ff, 64'hff0000ff00ffff00,
                                        64'h00ff00ff00ff00ff, 64'hff00ff00ff00ff00};
   localparam logic [6:0] PSI_PRE  = 7'd12;
   localparam logic [6:0] PSI_POST = 7'd61;
   localparam logic [3:0] PSI_MAX  = 4'd8;
   localparam logic [4:0] LAST_ROUND = 5'd31;
   localparam logic [4:0] KEY_REV_ROUND = 5'd24;
   localparam int ROT = 11;
   localparam logic [63:0] FULL_BITS = 64'd256;

   function automatic logic [31:0] round_fn(input logic [31:0] x, input sbox_type sb);
      logic [31:0] y;
      y = '0;
      for (int r = 0; r < 8; r++) begin
         y[4*r +: 4] = sb[r][4*x[4*r +: 4] +: 4];
      end
      return {y[31-ROT:0], y[31:32-ROT]};
   endfunction

   function automatic logic [255:0] psi1(input logic [255:0] x);
      logic [15:0] top;
      top = x[15:0] ^ x[31:16] ^ x[47:32] ^ x[63:48] ^ x[207:192] ^ x[255:240];
      return {top, x[255:16]};
   endfunction

   function automatic logic [255:0] psi_n(input logic [255:0] x, input logic [3:0] n);
      logic [255:0] y;
      y = x;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < n) y = psi1(y);
      end
      return y;
   endfunction

endpackage

>>> rtl/ghe_front.sv
module ghe_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [63:0]        req_block_word_0,
   input  logic [63:0]        req_block_word_1,
   input  logic [63:0]        req_block_word_2,
   input  logic [63:0]        req_block_word_3,
   input  logic [4:0]         req_byte_count,
   output logic               q_valid,
   output ghe_pkg::qent_type  q_data,
   input  logic               q_pop
);
   import ghe_pkg::*;

   qent_type   ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   qent_type   ent_new;
   logic [255:0] raw;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = ent_ff[rd_ptr_ff];

   // finish beats drop bytes at or past the byte count
   always_comb begin
      raw = {req_block_word_3, req_block_word_2, req_block_word_1, req_block_word_0};
      ent_new.finish    = req_action;
      ent_new.has_block = !req_action || (req_byte_count != 5'd0);
      ent_new.nbytes    = req_byte_count;
      for (int i = 0; i < 32; i++) begin
         ent_new.block[8*i +: 8] = (!req_action || (5'(i) < req_byte_count)) ?
                                   raw[8*i +: 8] : 8'h00;
      end
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ptr_ff] <= ent_new;
   end

endmodule

>>> rtl/ghe_compress.sv
module ghe_compress (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [255:0]          h_in,
   input  logic [255:0]          m_in,
   input  ghe_pkg::sbox_type     sbox,
   output ghe_pkg::cmp_stat_type stat,
   output logic [255:0]          h_out
);
   import ghe_pkg::*;

   typedef enum logic [4:0] {
      C_IDLE = 5'b00001,
      C_ENC  = 5'b00010,
      C_PRE  = 5'b00100,
      C_MID  = 5'b01000,
      C_POST = 5'b10000
   } cstate_type;

   cstate_type state_ff, state_in;
   logic [3:0][7:0][31:0] key_ff, key_in, key_c;
   logic [3:0][31:0] n1_ff, n1_in, n2_ff, n2_in;
   logic [4:0]   rnd_ff, rnd_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [255:0] mix_ff, mix_in, h_ff, h_in_sel, m_ff, m_in_sel;
   logic [3:0]   step;
   logic [2:0]   kidx;
   logic [255:0] psi_out;

   // key schedule for all four encryptions from h and m
   always_comb begin
      logic [255:0] u, v, w;
      logic [63:0]  t, t2;
      u = h_in;
      v = m_in;
      key_c = '0;
      for (int s = 0; s < 4; s++) begin
         w = u ^ v;
         for (int j = 0; j < 8; j++) begin
            for (int i = 0; i < 4; i++) begin
               key_c[s][j][8*i +: 8] = w[64*i + 8*j +: 8];
            end
         end
         t = u[63:0] ^ u[127:64];
         u = {t, u[255:64]};
         if (s == 1) u = u ^ C3_CONST;
         t  = v[63:0] ^ v[127:64];
         t2 = v[127:64] ^ v[191:128];
         v  = {t2, t, v[255:128]};
      end
   end

   assign kidx    = (rnd_ff < KEY_REV_ROUND) ? rnd_ff[2:0] : ~rnd_ff[2:0];
   assign step    = (cnt_ff >= 7'(PSI_MAX)) ? PSI_MAX : cnt_ff[3:0];
   assign psi_out = psi_n(mix_ff, step);
   assign h_out   = psi_out;
   assign stat.busy = (state_ff != C_IDLE);
   assign stat.done = (state_ff == C_POST) && (cnt_ff <= 7'(PSI_MAX));

   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      n1_in    = n1_ff;
      n2_in    = n2_ff;
      rnd_in   = rnd_ff;
      cnt_in   = cnt_ff;
      mix_in   = mix_ff;
      h_in_sel = h_ff;
      m_in_sel = m_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               key_in   = key_c;
               h_in_sel = h_in;
               m_in_sel = m_in;
               for (int l = 0; l < 4; l++) begin
                  n1_in[l] = h_in[64*l +: 32];
                  n2_in[l] = h_in[64*l + 32 +: 32];
               end
               rnd_in   = 5'd0;
               state_in = C_ENC;
            end
         end
         C_ENC: begin
            for (int l = 0; l < 4; l++) begin
               if (!rnd_ff[0]) n2_in[l] = n2_ff[l] ^ round_fn(n1_ff[l] + key_ff[l][kidx], sbox);
               else            n1_in[l] = n1_ff[l] ^ round_fn(n2_ff[l] + key_ff[l][kidx], sbox);
            end
            rnd_in = rnd_ff + 5'd1;
            if (rnd_ff == LAST_ROUND) begin
               for (int l = 0; l < 4; l++) begin
                  mix_in[64*l +: 32]      = n2_in[l];
                  mix_in[64*l + 32 +: 32] = n1_in[l];
               end
               cnt_in   = PSI_PRE;
               state_in = C_PRE;
            end
         end
         C_PRE: begin
            mix_in = psi_out;
            cnt_in = cnt_ff - 7'(step);
            if (cnt_in == 7'd0) state_in = C_MID;
         end
         C_MID: begin
            mix_in   = psi1(mix_ff ^ m_ff) ^ h_ff;
            cnt_in   = PSI_POST;
            state_in = C_POST;
         end
         C_POST: begin
            mix_in = psi_out;
            cnt_in = cnt_ff - 7'(step);
            if (cnt_in == 7'd0) state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= C_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      n1_ff  <= n1_in;
      n2_ff  <= n2_in;
      rnd_ff <= rnd_in;
      cnt_ff <= cnt_in;
      mix_ff <= mix_in;
      h_ff   <= h_in_sel;
      m_ff   <= m_in_sel;
   end

endmodule

>>> rtl/ghe_back.sv
module ghe_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  ghe_pkg::qent_type     q_data,
   output logic                  q_pop,
   output logic                  cmp_start,
   output logic [255:0]          cmp_h,
   output logic [255:0]          cmp_m,
   input  ghe_pkg::cmp_stat_type cmp_stat,
   input  logic [255:0]          cmp_h_out,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [63:0]           rsp_digest_word,
   output logic [1:0]            rsp_word_index,
   output logic                  rsp_last_word
);
   import ghe_pkg::*;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_RUN  = 3'b010,
      B_EMIT = 3'b100
   } bstate_type;

   typedef enum logic [2:0] {
      K_BLK = 3'b001,
      K_LEN = 3'b010,
      K_SUM = 3'b100
   } kind_type;

   bstate_type   state_ff, state_in;
   kind_type     kind_ff, kind_in;
   logic         fin_ff, fin_in;
   logic         start_ff, start_in;
   logic [255:0] blk_ff, blk_in, hash_ff, hash_in, sum_ff, sum_in, dig_ff, dig_in;
   logic [63:0]  len_ff, len_in;
   logic         rvalid_ff, rvalid_in;
   logic [1:0]   widx_ff, widx_in;

   assign cmp_start = start_ff;
   assign cmp_h     = hash_ff;
   always_comb begin
      unique case (kind_ff)
         K_BLK:   cmp_m = blk_ff;
         K_LEN:   cmp_m = {192'd0, len_ff};
         K_SUM:   cmp_m = sum_ff;
         default: cmp_m = blk_ff;
      endcase
   end

   assign rsp_valid       = rvalid_ff;
   assign rsp_word_index  = widx_ff;
   assign rsp_last_word   = (widx_ff == 2'd3);
   assign rsp_digest_word = dig_ff[64*widx_ff +: 64];

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      fin_in    = fin_ff;
      start_in  = 1'b0;
      blk_in    = blk_ff;
      hash_in   = hash_ff;
      sum_in    = sum_ff;
      len_in    = len_ff;
      dig_in    = dig_ff;
      rvalid_in = rvalid_ff;
      widx_in   = widx_ff;
      q_pop     = 1'b0;
      if (rvalid_ff && !rsp_stall) begin
         if (widx_ff == 2'd3) rvalid_in = 1'b0;
         else                 widx_in   = widx_ff + 2'd1;
      end
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               blk_in   = q_data.block;
               fin_in   = q_data.finish;
               start_in = 1'b1;
               state_in = B_RUN;
               if (q_data.has_block) begin
                  sum_in  = sum_ff + q_data.block;
                  len_in  = len_ff + (q_data.finish ? {56'd0, q_data.nbytes, 3'd0} : FULL_BITS);
                  kind_in = K_BLK;
               end else begin
                  kind_in = K_LEN;
               end
            end
         end
         B_RUN: begin
            if (cmp_stat.done) begin
               hash_in = cmp_h_out;
               unique case (kind_ff)
                  K_BLK: begin
                     if (fin_ff) begin
                        kind_in  = K_LEN;
                        start_in = 1'b1;
                     end else begin
                        state_in = B_IDLE;
                     end
                  end
                  K_LEN: begin
                     kind_in  = K_SUM;
                     start_in = 1'b1;
                  end
                  K_SUM:   state_in = B_EMIT;
                  default: state_in = B_IDLE;
               endcase
            end
         end
         B_EMIT: begin
            // previous digest must be fully drained first
            if (!rvalid_ff) begin
               dig_in    = hash_ff;
               rvalid_in = 1'b1;
               widx_in   = 2'd0;
               hash_in   = '0;
               sum_in    = '0;
               len_in    = '0;
               state_in  = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         kind_ff   <= K_BLK;
         start_ff  <= 1'b0;
         rvalid_ff <= 1'b0;
         widx_ff   <= 2'd0;
         hash_ff   <= '0;
         sum_ff    <= '0;
         len_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         kind_ff   <= kind_in;
         start_ff  <= start_in;
         rvalid_ff <= rvalid_in;
         widx_ff   <= widx_in;
         hash_ff   <= hash_in;
         sum_ff    <= sum_in;
         len_ff    <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
      blk_ff <= blk_in;
      dig_ff <= dig_in;
   end

endmodule

>>> rtl/gost94_hash_engine.sv
// channel   dir  handshake            payload
// req       in   req_valid/req_stall  action, block_word_0..3, byte_count
// rsp       out  rsp_valid/rsp_stall  digest_word, word_index, last_word
// csr       in   csr_write            csr_index, csr_data (s-box rows)
// one compression runs a start step, 32 rounds of the four parallel encryptions,
// then pre-shuffle, message mix and post-shuffle; write-back overlaps the last step
// an absorb beat holds the sequencer for one compression with its queue pop, a finish
// beat for two or three compressions plus the digest load
// a two-beat queue decouples req from the compression sequencer
// the four digest beats drain from an output buffer while the next block runs
// reset is synchronous and clears hash, checksum, length and s-box rows
module gost94_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [63:0] req_block_word_0,
   input  logic [63:0] req_block_word_1,
   input  logic [63:0] req_block_word_2,
   input  logic [63:0] req_block_word_3,
   input  logic [4:0]  req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import ghe_pkg::*;

   sbox_type     sbox_ff;
   logic         q_valid, q_pop, cmp_start;
   qent_type     q_data;
   logic [255:0] cmp_h, cmp_m, cmp_h_out;
   cmp_stat_type cmp_stat;

   always_ff @(posedge clock) begin
      if (reset)          sbox_ff            <= '0;
      else if (csr_write) sbox_ff[csr_index] <= csr_data;
   end

   ghe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_block_word_0 (req_block_word_0),
      .req_block_word_1 (req_block_word_1),
      .req_block_word_2 (req_block_word_2),
      .req_block_word_3 (req_block_word_3),
      .req_byte_count   (req_byte_count),
      .q_valid          (q_valid),
      .q_data           (q_data),
      .q_pop            (q_pop)
   );

   ghe_compress u_compress (
      .clock (clock),
      .reset (reset),
      .start (cmp_start),
      .h_in  (cmp_h),
      .m_in  (cmp_m),
      .sbox  (sbox_ff),
      .stat  (cmp_stat),
      .h_out (cmp_h_out)
   );

   ghe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .cmp_start       (cmp_start),
      .cmp_h           (cmp_h),
      .cmp_m           (cmp_m),
      .cmp_stat        (cmp_stat),
      .cmp_h_out       (cmp_h_out),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmp_start |-> !cmp_stat.busy) else $error("compress started while busy");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      cmp_stat.done |-> cmp_stat.busy) else $error("compress done while idle");
   a_last_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word) |=> !rsp_valid)
      else $error("digest reloaded on last beat");
`endif

endmodule

>>> bench/gost94_hash_checker.sv
`timescale 1ns / 1ps

module gost94_hash_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_action,
   input  logic [63:0] req_block_word_0,
   input  logic [63:0] req_block_word_1,
   input  logic [63:0] req_block_word_2,
   input  logic [63:0] req_block_word_3,
   input  logic [4:0]  req_byte_count,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_digest_word,
   input  logic [1:0]  rsp_word_index,
   input  logic        rsp_last_word,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          fail_count,
   output int          pending_words
);

   localparam logic ACT_ABSORB = 1'b0;
   localparam logic [63:0] C3_W [4] = '{64'hff00ff00ff00ff00, 64'h00ff00ff00ff00ff,
                                        64'hff0000ff00ffff00, 64'hff00ffff000000ff};

   typedef struct packed {
      logic [63:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_beat_type;

   logic [63:0] sbox_rows [8];
   logic [63:0] hash_st [4];
   logic [63:0] sum_st [4];
   logic [63:0] length_bits;
   digest_beat_type digest_q [$];

   assign pending_words = digest_q.size();

   function automatic logic [31:0] sub_rot(input logic [31:0] x);
      logic [31:0] y;
      y = '0;
      for (int r = 0; r < 8; r++)
         y[4*r +: 4] = sbox_rows[r][4*x[4*r +: 4] +: 4];
      return {y[20:0], y[31:21]};
   endfunction

   function automatic logic [63:0] cipher(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] key [8]);
      logic [31:0] n1, n2, k;
      n1 = a;
      n2 = b;
      for (int r = 0; r < 32; r++) begin
         k = (r < 24) ? key[r % 8] : key[7 - (r % 8)];
         if (r % 2 == 0) n2 ^= sub_rot(n1 + k);
         else n1 ^= sub_rot(n2 + k);
      end
      return {n1, n2};
   endfunction

   function automatic logic [255:0] shuffle(input logic [255:0] x);
      logic [15:0] top;
      top = x[15:0] ^ x[31:16] ^ x[47:32] ^ x[63:48] ^ x[207:192] ^ x[255:240];
      return {top, x[255:16]};
   endfunction

   task automatic compress_block(input logic [63:0] m [4]);
      logic [63:0] u [4], v [4], w [4], t, t2;
      logic [31:0] key [8];
      logic [63:0] enc [4];
      logic [255:0] mix, mw, hw;
      for (int i = 0; i < 4; i++) begin
         u[i] = hash_st[i];
         v[i] = m[i];
         w[i] = u[i] ^ v[i];
      end
      for (int s = 0; s < 4; s++) begin
         for (int j = 0; j < 8; j++)
            for (int i = 0; i < 4; i++) key[j][8*i +: 8] = w[i][8*j +: 8];
         enc[s] = cipher(hash_st[s][31:0], hash_st[s][63:32], key);
         if (s < 3) begin
            t = u[0] ^ u[1];
            u[0] = u[1]; u[1] = u[2]; u[2] = u[3]; u[3] = t;
            if (s == 1) for (int i = 0; i < 4; i++) u[i] ^= C3_W[i];
            t = v[0] ^ v[1];
            t2 = v[1] ^ v[2];
            v[0] = v[2]; v[1] = v[3]; v[2] = t; v[3] = t2;
            for (int i = 0; i < 4; i++) w[i] = u[i] ^ v[i];
         end
      end
      mix = {enc[3], enc[2], enc[1], enc[0]};
      mw = {m[3], m[2], m[1], m[0]};
      hw = {hash_st[3], hash_st[2], hash_st[1], hash_st[0]};
      for (int i = 0; i < 12; i++) mix = shuffle(mix);
      mix = shuffle(mix ^ mw) ^ hw;
      for (int i = 0; i < 61; i++) mix = shuffle(mix);
      for (int i = 0; i < 4; i++) hash_st[i] = mix[64*i +: 64];
   endtask

   task automatic absorb(input logic [63:0] m [4]);
      logic [256:0] acc;
      acc = {1'b0, sum_st[3], sum_st[2], sum_st[1], sum_st[0]} + {1'b0, m[3], m[2], m[1], m[0]};
      for (int i = 0; i < 4; i++) sum_st[i] = acc[64*i +: 64];
      compress_block(m);
   endtask

   task automatic predict_beat(input logic act, input logic [63:0] blk [4], input logic [4:0] n);
      logic [63:0] m [4];
      m = blk;
      if (act == ACT_ABSORB) begin
         length_bits += 64'd256;
         absorb(m);
      end else begin
         if (n != 0) begin
            for (int i = 0; i < 32; i++) if (i >= n) m[i/8][8*(i%8) +: 8] = 8'h00;
            length_bits += 64'(n) * 64'd8;
            absorb(m);
         end
         m = '{length_bits, 64'd0, 64'd0, 64'd0};
         compress_block(m);
         m = sum_st;
         compress_block(m);
         for (int i = 0; i < 4; i++) digest_q.push_back('{hash_st[i], 2'(i), i == 3});
         for (int i = 0; i < 4; i++) begin
            hash_st[i] = '0;
            sum_st[i] = '0;
         end
         length_bits = '0;
      end
   endtask

   always @(posedge clock) begin
      digest_beat_type exp_beat;
      logic [63:0] blk [4];
      if (reset) begin
         fail_count <= 0;
         for (int i = 0; i < 8; i++) sbox_rows[i] = '0;
         for (int i = 0; i < 4; i++) begin
            hash_st[i] = '0;
            sum_st[i] = '0;
         end
         length_bits = '0;
         digest_q.delete();
      end else begin
         if (csr_write) sbox_rows[csr_index] = csr_data;
         if (req_valid && !req_stall) begin
            blk = '{req_block_word_0, req_block_word_1, req_block_word_2, req_block_word_3};
            predict_beat(req_action, blk, req_byte_count);
         end
         if (rsp_valid && !rsp_stall) begin
            if (digest_q.size() == 0) begin
               $display("%0t: unexpected digest beat %h idx %0d", $time,
                        rsp_digest_word, rsp_word_index);
               fail_count <= fail_count + 1;
            end else begin
               exp_beat = digest_q.pop_front();
               if (exp_beat != {rsp_digest_word, rsp_word_index, rsp_last_word}) begin
                  $display("%0t: digest mismatch exp %h/%0d/%0d got %h/%0d/%0d", $time,
                           exp_beat.word, exp_beat.index, exp_beat.last,
                           rsp_digest_word, rsp_word_index, rsp_last_word);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> bench/tb_gost94_hash_engine.sv
`timescale 1ns / 1ps

module tb_gost94_hash_engine;

   localparam logic ACT_ABSORB = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = ACT_ABSORB;
   logic [63:0] req_block_word_0 = '0;
   logic [63:0] req_block_word_1 = '0;
   logic [63:0] req_block_word_2 = '0;
   logic [63:0] req_block_word_3 = '0;
   logic [4:0]  req_byte_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last_word;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   int          fail_count;
   int          pending_words;
   int          send_idle_pct = 0;
   int          stall_pct = 0;

   always #6 clock = ~clock;

   gost94_hash_engine dut (.*);
   gost94_hash_checker u_checker (.*);

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   // valid stays up between back-to-back beats and drops only while idling
   task automatic send_beat(input logic act, input logic [63:0] w0, input logic [63:0] w1,
                            input logic [63:0] w2, input logic [63:0] w3, input logic [4:0] n);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_block_word_0 <= w0;
      req_block_word_1 <= w1;
      req_block_word_2 <= w2;
      req_block_word_3 <= w3;
      req_byte_count <= n;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random(input logic act);
      send_beat(act, rnd64(), rnd64(), rnd64(), rnd64(), 5'($urandom_range(31)));
   endtask

   // drain results and let a trailing compression settle before touching csr
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic load_sboxes(input int mode);
      logic [63:0] row;
      for (int r = 0; r < 8; r++) begin
         case (mode)
            0: row = 64'hfedcba9876543210;
            1: row = 64'h0;
            2: row = 64'hffffffffffffffff;
            default: row = rnd64();
         endcase
         csr_write <= 1'b1;
         csr_index <= 3'(r);
         csr_data <= row;
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   initial begin
      #50ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int nblk;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty message under the reset s-box of zeros
      send_beat(ACT_FINISH, '0, '0, '0, '0, 5'd0);
      wait_idle();
      load_sboxes(0);
      send_beat(ACT_FINISH, '1, '1, '1, '1, 5'd31);
      send_beat(ACT_FINISH, '1, '1, '1, '1, 5'd1);
      send_beat(ACT_ABSORB, '1, '1, '1, '1, 5'd0);
      send_beat(ACT_ABSORB, '1, '1, '1, '1, 5'd7);
      send_beat(ACT_FINISH, '0, '0, '0, '0, 5'd0);
      send_beat(ACT_ABSORB, 64'h0123456789abcdef, '0, '0, 64'h8000000000000000, 5'd0);
      send_beat(ACT_FINISH, rnd64(), rnd64(), rnd64(), rnd64(), 5'd16);
      wait_idle();
      load_sboxes(2);
      send_beat(ACT_ABSORB, rnd64(), rnd64(), rnd64(), rnd64(), 5'd0);
      send_beat(ACT_FINISH, rnd64(), rnd64(), rnd64(), rnd64(), 5'd8);
      wait_idle();
      load_sboxes(3);
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 57; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 57; end
            3: begin send_idle_pct = 29; stall_pct = 29; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         for (int m = 0; m < 6; m++) begin
            nblk = $urandom_range(4);
            for (int b = 0; b < nblk; b++) send_random(ACT_ABSORB);
            send_random(ACT_FINISH);
            if (m == 2) wait_idle();
         end
         wait_idle();
         if (ph == 2) load_sboxes($urandom_range(3));
      end
      wait_idle();
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> gost94_hash_engine.f
rtl/ghe_pkg.sv
rtl/ghe_front.sv
rtl/ghe_compress.sv
rtl/ghe_back.sv
rtl/gost94_hash_engine.sv
bench/gost94_hash_checker.sv
bench/tb_gost94_hash_engine.sv
